### hw/rtl/pws_pkg.sv
// Shared types and constants for the perspective warp sampler.
// Used by perspective_warp_sampler_unit; no dependencies.
`default_nettype none
package pws_pkg;

	typedef enum logic [1:0] {
		CMD_PIXEL   = 2'd0,
		CMD_COEF    = 2'd1,
		CMD_COMPUTE = 2'd2
	} cmd_t;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_BORDER_MODE   = 3'd0;
	localparam logic [2:0] REG_INTERP_MODE   = 3'd1;
	localparam logic [2:0] REG_BORDER_VALUE  = 3'd2;
	localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd3;
	localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd4;

	localparam logic [1:0] BORDER_CONST  = 2'd0;
	localparam logic [1:0] BORDER_REPL   = 2'd1;
	localparam logic [1:0] BORDER_TRANSP = 2'd2;

	// Saturated magnitude of a source coordinate
	localparam logic [21:0] COORD_SAT = 22'h10_0000;

	// Sideband that travels with every transaction in the pipeline
	typedef struct packed {
		logic        wr;
		logic        comp;
		logic [11:0] row;
		logic [11:0] col;
		logic [31:0] pix;
	} side_t;

	typedef struct packed {
		logic signed [22:0] base;
		logic [7:0]         frac;
	} coord_t;

endpackage
`default_nettype wire

### hw/rtl/pws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire              clk,
	input  wire              we,
	input  wire [AW-1:0]     waddr,
	input  wire [WIDTH-1:0]  wdata,
	input  wire [AW-1:0]     raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hw/rtl/perspective_warp_sampler_unit.sv
// Perspective warp sampler: projection, pipelined division, banked source image
// and bilinear / nearest sampling. Depends on pws_pkg and pws_ram.
// Throughput: one transaction per cycle, busy never raised; the 30-stage divider sets depth.
// Reset: configuration registers take their reset values and all pipeline valid bits
// clear; source image and matrix hold no reset value.
`default_nettype none
module perspective_warp_sampler_unit #(
	parameter int MAX_SRC_WIDTH  = 256,
	parameter int MAX_SRC_HEIGHT = 256,
	parameter int CHANNELS       = 4
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [4:0]        paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire               start,
	output logic              busy,
	input  wire  [1:0]        cmd,
	input  wire  [11:0]       pos_row,
	input  wire  [11:0]       pos_col,
	input  wire  [3:0]        coef_index,
	input  wire signed [47:0] coef_value,
	input  wire  [31:0]       pixel_in,
	output logic              result_valid,
	output logic [31:0]       pixel_out,
	output logic              write_enable,
	output logic [11:0]       out_row,
	output logic [11:0]       out_col
);
	import pws_pkg::*;

	localparam int HALF_W     = (MAX_SRC_WIDTH + 1) / 2;
	localparam int HALF_H     = (MAX_SRC_HEIGHT + 1) / 2;
	localparam int BANK_DEPTH = HALF_W * HALF_H;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam logic [31:0] CHAN_MASK = 32'((64'd1 << (8 * CHANNELS)) - 64'd1);
	localparam int DIV_N = 30;

	// ---------------- configuration ----------------
	logic [1:0] border_mode_q;
	logic       interp_mode_q;
	logic [7:0] border_value_q;
	logic [8:0] source_width_q;
	logic [8:0] source_height_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_mode_q   <= BORDER_CONST;
			interp_mode_q   <= 1'b0;
			border_value_q  <= 8'd0;
			source_width_q  <= 9'd256;
			source_height_q <= 9'd256;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_BORDER_MODE:   border_mode_q   <= pwdata[1:0];
				REG_INTERP_MODE:   interp_mode_q   <= pwdata[0];
				REG_BORDER_VALUE:  border_value_q  <= pwdata[7:0];
				REG_SOURCE_WIDTH:  source_width_q  <= pwdata[8:0];
				REG_SOURCE_HEIGHT: source_height_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[4:2])
			REG_BORDER_MODE:   prdata = 32'(border_mode_q);
			REG_INTERP_MODE:   prdata = 32'(interp_mode_q);
			REG_BORDER_VALUE:  prdata = 32'(border_value_q);
			REG_SOURCE_WIDTH:  prdata = 32'(source_width_q);
			REG_SOURCE_HEIGHT: prdata = 32'(source_height_q);
			default:           prdata = '0;
		endcase
	end

	logic        repl, transp;
	logic [12:0] eff_w, eff_h;
	logic [31:0] fill;

	assign repl   = (border_mode_q == BORDER_REPL);
	assign transp = (border_mode_q == BORDER_TRANSP);
	assign fill   = {4{border_value_q}} & CHAN_MASK;

	always_comb begin
		if (source_width_q == 9'd0) begin
			eff_w = 13'd1;
		end else if ({4'd0, source_width_q} > 13'(MAX_SRC_WIDTH)) begin
			eff_w = 13'(MAX_SRC_WIDTH);
		end else begin
			eff_w = {4'd0, source_width_q};
		end
		if (source_height_q == 9'd0) begin
			eff_h = 13'd1;
		end else if ({4'd0, source_height_q} > 13'(MAX_SRC_HEIGHT)) begin
			eff_h = 13'(MAX_SRC_HEIGHT);
		end else begin
			eff_h = {4'd0, source_height_q};
		end
	end

	// ---------------- input and matrix ----------------
	logic acc;
	assign busy = 1'b0;
	assign acc  = start & ~busy;

	logic signed [47:0] matrix_q [9];

	always_ff @(posedge clk) begin
		if (acc && cmd == CMD_COEF && coef_index < 4'd9) begin
			matrix_q[coef_index] <= coef_value;
		end
	end

	side_t side_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1.wr   <= acc && cmd == CMD_PIXEL;
			side_s1.comp <= acc && cmd == CMD_COMPUTE;
			side_s1.row  <= pos_row;
			side_s1.col  <= pos_col;
			side_s1.pix  <= pixel_in & CHAN_MASK;
		end
	end

	// ---------------- projection ----------------
	logic signed [12:0] colx, rowx;
	assign colx = $signed({1'b0, side_s1.col});
	assign rowx = $signed({1'b0, side_s1.row});

	side_t              side_s2;
	logic signed [60:0] prod_s2 [6];
	logic signed [47:0] cst_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else begin
			side_s2 <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2[0] <= matrix_q[0] * colx;
		prod_s2[1] <= matrix_q[1] * rowx;
		prod_s2[2] <= matrix_q[3] * colx;
		prod_s2[3] <= matrix_q[4] * rowx;
		prod_s2[4] <= matrix_q[6] * colx;
		prod_s2[5] <= matrix_q[7] * rowx;
		cst_s2[0]  <= matrix_q[2];
		cst_s2[1]  <= matrix_q[5];
		cst_s2[2]  <= matrix_q[8];
	end

	side_t              side_s3;
	logic signed [62:0] x_s3, y_s3, w_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else begin
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s3 <= prod_s2[0] + prod_s2[1] + cst_s2[0];
		y_s3 <= prod_s2[2] + prod_s2[3] + cst_s2[1];
		w_s3 <= prod_s2[4] + prod_s2[5] + cst_s2[2];
	end

	// magnitudes and quotient signs
	side_t       side_s4;
	logic [62:0] nx_s4, ny_s4, dw_s4;
	logic        negx_s4, negy_s4, wz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else begin
			side_s4 <= side_s3;
		end
	end

	always_ff @(posedge clk) begin
		nx_s4   <= x_s3[62] ? 63'(63'd0 - x_s3) : x_s3;
		ny_s4   <= y_s3[62] ? 63'(63'd0 - y_s3) : y_s3;
		dw_s4   <= w_s3[62] ? 63'(63'd0 - w_s3) : w_s3;
		negx_s4 <= x_s3[62] ^ w_s3[62];
		negy_s4 <= y_s3[62] ^ w_s3[62];
		wz_s4   <= (w_s3 == 63'sd0);
	end

	// ---------------- divider: one quotient bit per stage ----------------
	// Quotient is floor(N*256/D); bit 29 flags an integer part of 2^21 or more.
	side_t       div_side_s [DIV_N];
	logic [70:0] div_rx_s   [DIV_N];
	logic [70:0] div_ry_s   [DIV_N];
	logic [62:0] div_d_s    [DIV_N];
	logic [29:0] div_qx_s   [DIV_N];
	logic [29:0] div_qy_s   [DIV_N];
	logic        div_negx_s [DIV_N];
	logic        div_negy_s [DIV_N];
	logic        div_wz_s   [DIV_N];

	for (genvar j = 0; j < DIV_N; j++) begin : g_div
		localparam int SH = DIV_N - 1 - j;
		side_t       sd_in;
		logic [70:0] rx_in, ry_in;
		logic [62:0] d_in;
		logic [29:0] qx_in, qy_in;
		logic        nx_in, ny_in, wz_in;
		logic [91:0] dsh, rxe, rye;
		logic        gex, gey;

		if (j == 0) begin : g_first
			assign sd_in = side_s4;
			assign rx_in = {nx_s4, 8'd0};
			assign ry_in = {ny_s4, 8'd0};
			assign d_in  = dw_s4;
			assign qx_in = '0;
			assign qy_in = '0;
			assign nx_in = negx_s4;
			assign ny_in = negy_s4;
			assign wz_in = wz_s4;
		end else begin : g_next
			assign sd_in = div_side_s[j-1];
			assign rx_in = div_rx_s[j-1];
			assign ry_in = div_ry_s[j-1];
			assign d_in  = div_d_s[j-1];
			assign qx_in = div_qx_s[j-1];
			assign qy_in = div_qy_s[j-1];
			assign nx_in = div_negx_s[j-1];
			assign ny_in = div_negy_s[j-1];
			assign wz_in = div_wz_s[j-1];
		end

		assign dsh = 92'(d_in) << SH;
		assign rxe = 92'(rx_in);
		assign rye = 92'(ry_in);
		assign gex = (rxe >= dsh);
		assign gey = (rye >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_side_s[j] <= '0;
			end else begin
				div_side_s[j] <= sd_in;
			end
		end

		always_ff @(posedge clk) begin
			div_rx_s[j]   <= gex ? 71'(rxe - dsh) : rx_in;
			div_ry_s[j]   <= gey ? 71'(rye - dsh) : ry_in;
			div_qx_s[j]   <= {qx_in[28:0], gex};
			div_qy_s[j]   <= {qy_in[28:0], gey};
			div_d_s[j]    <= d_in;
			div_negx_s[j] <= nx_in;
			div_negy_s[j] <= ny_in;
			div_wz_s[j]   <= wz_in;
		end
	end

	// ---------------- quotient to source coordinate ----------------
	function automatic coord_t quot_to_coord(input logic [29:0] q, input logic sticky,
			input logic neg, input logic bilin);
		logic [21:0] rq;
		logic [28:0] m;
		logic [28:0] mag;
		logic [29:0] fx;
		coord_t      res;
		if (!bilin) begin
			rq = {1'b0, q[28:8]} + 22'(q[7]);
			if (q[29] || rq > COORD_SAT) begin
				rq = COORD_SAT;
			end
			res.base = neg ? 23'(23'd0 - {1'b0, rq}) : {1'b0, rq};
			res.frac = 8'd0;
		end else begin
			if (q[29] || q[28]) begin
				m   = 29'h1000_0000;
				mag = m;
			end else begin
				m   = {1'b0, q[27:0]};
				mag = m + 29'(sticky);
			end
			fx = neg ? 30'(30'd0 - {1'b0, mag}) : {1'b0, m};
			// floor by 256 is an arithmetic shift; the low byte is the weight
			res.base = {fx[29], fx[29:8]};
			res.frac = fx[7:0];
		end
		return res;
	endfunction

	side_t  side_s5;
	coord_t cx_s5, cy_s5;
	logic   wz_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s5 <= '0;
		end else begin
			side_s5 <= div_side_s[DIV_N-1];
		end
	end

	always_ff @(posedge clk) begin
		cx_s5 <= quot_to_coord(div_qx_s[DIV_N-1], |div_rx_s[DIV_N-1],
			div_negx_s[DIV_N-1], interp_mode_q);
		cy_s5 <= quot_to_coord(div_qy_s[DIV_N-1], |div_ry_s[DIV_N-1],
			div_negy_s[DIV_N-1], interp_mode_q);
		wz_s5 <= div_wz_s[DIV_N-1];
	end

	// ---------------- neighbors, border rule, weights ----------------
	logic signed [22:0] nr_c [4];
	logic signed [22:0] nc_c [4];
	logic [3:0]         ok_c;
	logic [16:0]        wt_c [4];
	logic signed [22:0] effw_s, effh_s;
	logic [8:0]         ui, vi, uc, vc;
	logic [17:0]        t0, t1, t2, t3;

	assign effw_s = $signed({10'd0, eff_w});
	assign effh_s = $signed({10'd0, eff_h});

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			nr_c[k] = cy_s5.base + 23'(k >> 1);
			nc_c[k] = cx_s5.base + 23'(k & 1);
			if (repl) begin
				if (nr_c[k] < 23'sd0) begin
					nr_c[k] = 23'sd0;
				end else if (nr_c[k] >= effh_s) begin
					nr_c[k] = effh_s - 23'sd1;
				end
				if (nc_c[k] < 23'sd0) begin
					nc_c[k] = 23'sd0;
				end else if (nc_c[k] >= effw_s) begin
					nc_c[k] = effw_s - 23'sd1;
				end
			end
			ok_c[k] = (nr_c[k] >= 23'sd0) && (nr_c[k] < effh_s) &&
				(nc_c[k] >= 23'sd0) && (nc_c[k] < effw_s);
		end
	end

	always_comb begin
		ui = {1'b0, cx_s5.frac};
		vi = {1'b0, cy_s5.frac};
		uc = 9'd256 - ui;
		vc = 9'd256 - vi;
		t0 = uc * vc;
		t1 = ui * vc;
		t2 = uc * vi;
		t3 = ui * vi;
		wt_c[0] = t0[16:0];
		wt_c[1] = t1[16:0];
		wt_c[2] = t2[16:0];
		wt_c[3] = t3[16:0];
	end

	side_t       side_s6;
	logic [11:0] nrow_s6 [4];
	logic [11:0] ncol_s6 [4];
	logic [3:0]  ok_s6;
	logic [16:0] wt_s6 [4];
	logic        wz_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s6 <= '0;
		end else begin
			side_s6 <= side_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			nrow_s6[k] <= nr_c[k][11:0];
			ncol_s6[k] <= nc_c[k][11:0];
			wt_s6[k]   <= wt_c[k];
		end
		ok_s6 <= ok_c;
		wz_s6 <= wz_s5;
	end

	// ---------------- source image: four banks by row and column parity ----------------
	logic [BANK_AW-1:0] naddr [4];
	logic [BANK_AW-1:0] raddr [4];
	logic [BANK_AW-1:0] waddr;
	logic               wr_ok;
	logic [31:0]        bank_rd [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			naddr[k] = BANK_AW'((nrow_s6[k] >> 1) * HALF_W + (ncol_s6[k] >> 1));
		end
		// neighbors that share a bank are the same clamped pixel
		for (int b = 0; b < 4; b++) begin
			raddr[b] = '0;
			for (int k = 0; k < 4; k++) begin
				if ({nrow_s6[k][0], ncol_s6[k][0]} == 2'(b)) begin
					raddr[b] = naddr[k];
				end
			end
		end
	end

	assign waddr = BANK_AW'((side_s6.row >> 1) * HALF_W + (side_s6.col >> 1));
	assign wr_ok = side_s6.wr && ({1'b0, side_s6.row} < 13'(MAX_SRC_HEIGHT)) &&
		({1'b0, side_s6.col} < 13'(MAX_SRC_WIDTH));

	for (genvar b = 0; b < 4; b++) begin : g_bank
		pws_ram #(
			.WIDTH(32),
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk  (clk),
			.we   (wr_ok && {side_s6.row[0], side_s6.col[0]} == 2'(b)),
			.waddr(waddr),
			.wdata(side_s6.pix),
			.raddr(raddr[b]),
			.rdata(bank_rd[b])
		);
	end

	side_t       side_s7;
	logic [1:0]  par_s7 [4];
	logic [3:0]  ok_s7;
	logic [16:0] wt_s7 [4];
	logic        wz_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s7 <= '0;
		end else begin
			side_s7 <= side_s6;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			par_s7[k] <= {nrow_s6[k][0], ncol_s6[k][0]};
			wt_s7[k]  <= wt_s6[k];
		end
		ok_s7 <= ok_s6;
		wz_s7 <= wz_s6;
	end

	// ---------------- neighbor select ----------------
	side_t       side_s8;
	logic [31:0] nb_s8 [4];
	logic [3:0]  ok_s8;
	logic [16:0] wt_s8 [4];
	logic        wz_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s8 <= '0;
		end else begin
			side_s8 <= side_s7;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			nb_s8[k] <= ok_s7[k] ? bank_rd[par_s7[k]] : fill;
			wt_s8[k] <= wt_s7[k];
		end
		ok_s8 <= ok_s7;
		wz_s8 <= wz_s7;
	end

	// ---------------- blend products ----------------
	side_t       side_s9;
	logic [24:0] prod_s9 [4][4];
	logic [31:0] nb0_s9;
	logic [3:0]  ok_s9;
	logic        wz_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s9 <= '0;
		end else begin
			side_s9 <= side_s8;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				prod_s9[c][k] <= nb_s8[k][8*c +: 8] * wt_s8[k];
			end
		end
		nb0_s9 <= nb_s8[0];
		ok_s9  <= ok_s8;
		wz_s9  <= wz_s8;
	end

	// ---------------- sum and final select ----------------
	logic [25:0] sum_c;
	logic [31:0] blend_c;
	logic [31:0] pix_c;
	logic        we_c;

	always_comb begin
		blend_c = '0;
		for (int c = 0; c < 4; c++) begin
			sum_c = 26'(prod_s9[c][0]) + 26'(prod_s9[c][1]) +
				26'(prod_s9[c][2]) + 26'(prod_s9[c][3]);
			blend_c[8*c +: 8] = sum_c[23:16];
		end
		blend_c = blend_c & CHAN_MASK;
		priority if (wz_s9) begin
			we_c  = ~transp;
			pix_c = fill;
		end else if (!interp_mode_q) begin
			we_c  = ~(transp & ~ok_s9[0]);
			pix_c = nb0_s9;
		end else begin
			we_c  = ~(transp & ~(&ok_s9));
			pix_c = blend_c;
		end
		if (!we_c) begin
			pix_c = '0;
		end
	end

	logic        valid_s10;
	logic [31:0] pix_s10;
	logic        we_s10;
	logic [11:0] row_s10, col_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else begin
			valid_s10 <= side_s9.comp;
		end
	end

	always_ff @(posedge clk) begin
		pix_s10 <= pix_c;
		we_s10  <= we_c;
		row_s10 <= side_s9.row;
		col_s10 <= side_s9.col;
	end

	assign result_valid = valid_s10;
	assign pixel_out    = pix_s10;
	assign write_enable = we_s10;
	assign out_row      = row_s10;
	assign out_col      = col_s10;
endmodule
`default_nettype wire

### tb/perspective_warp_sampler_unit_tb.sv
// Self-checking testbench for the perspective warp sampler: loads source images and
// matrices, predicts every output pixel in-line and compares it with the block's results.
// Depends on pws_pkg and perspective_warp_sampler_unit.
`default_nettype none
module perspective_warp_sampler_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pws_pkg::*;

	localparam int IMG_W = 256;
	localparam int IMG_H = 256;
	localparam int FLUSH_CYCLES = 48;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] BORDER_ALT = 2'd3;
	localparam logic INTERP_NEAREST = 1'b0;
	localparam logic INTERP_BILINEAR = 1'b1;
	localparam longint signed ONE_Q32 = 64'sd1 <<< 32;
	localparam longint unsigned SAT_MAG = 64'd1 << 20;
	localparam int MAT_WELL = 0;
	localparam int MAT_NOISE = 1;
	localparam int MAT_ZERO_W = 2;

	typedef struct {
		logic [1:0]  op;
		logic [11:0] row;
		logic [11:0] col;
		logic [3:0]  cidx;
		logic [47:0] cval;
		logic [31:0] pin;
		bit          drain;
	} job_t;

	typedef struct {
		logic [31:0] pix;
		logic        we;
		logic [11:0] row;
		logic [11:0] col;
	} pix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [1:0] cmd = '0;
	logic [11:0] pos_row = '0, pos_col = '0;
	logic [3:0] coef_index = '0;
	logic signed [47:0] coef_value = '0;
	logic [31:0] pixel_in = '0;
	logic result_valid;
	logic [31:0] pixel_out;
	logic write_enable;
	logic [11:0] out_row, out_col;

	perspective_warp_sampler_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.cmd(cmd), .pos_row(pos_row), .pos_col(pos_col), .coef_index(coef_index),
		.coef_value(coef_value), .pixel_in(pixel_in),
		.result_valid(result_valid), .pixel_out(pixel_out), .write_enable(write_enable),
		.out_row(out_row), .out_col(out_col)
	);

	// shadow state of the block
	logic [31:0] src_img [IMG_W*IMG_H];
	longint signed warp_mat [9];
	logic [1:0] cfg_border = BORDER_CONST;
	logic cfg_interp = INTERP_NEAREST;
	logic [7:0] cfg_fill = '0;
	logic [8:0] cfg_width = 9'd256;
	logic [8:0] cfg_height = 9'd256;

	job_t pending_jobs [$];
	pix_t expected_pixels [$];
	job_t cur_job;
	int gap_left = 0;
	bit gaps_on = 1'b1;
	int errors = 0;
	int mat_kind = MAT_WELL;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint signed eff_dim(logic [8:0] v, int lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic longint unsigned mag(longint signed v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// quotient rounded half away from zero, magnitude saturated
	function automatic longint signed div_nearest(longint signed n, longint signed d);
		longint unsigned an, ad, q, r;
		an = mag(n);
		ad = mag(d);
		q = an / ad;
		r = an % ad;
		if (r >= ad - r)
			q++;
		if (q > SAT_MAG)
			q = SAT_MAG;
		return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
	endfunction

	// floor of the quotient in 1/256 steps
	function automatic longint signed div_floor_q8(longint signed n, longint signed d);
		longint unsigned an, ad, q, r, f;
		an = mag(n);
		ad = mag(d);
		q = an / ad;
		r = an % ad;
		f = 0;
		if (q >= SAT_MAG) begin
			q = SAT_MAG;
			r = 0;
		end
		for (int i = 0; i < 8; i++) begin
			r = r << 1;
			f = f << 1;
			if (r >= ad) begin
				r = r - ad;
				f = f | 1;
			end
		end
		if ((n < 0) != (d < 0))
			return -longint'(q * 256 + f + (r != 0 ? 1 : 0));
		return longint'(q * 256 + f);
	endfunction

	function automatic longint signed clip(longint signed v, longint signed hi);
		return v < 0 ? 0 : (v > hi ? hi : v);
	endfunction

	function automatic pix_t warp_pixel(logic [11:0] r, logic [11:0] c);
		pix_t o;
		logic [1:0] md;
		longint signed x, y, w, sx, sy, fx, fy, x0, y0, ew, eh;
		longint signed rr [4];
		longint signed cc [4];
		logic [31:0] nb [4];
		bit ok [4];
		int unsigned u, v, sum;
		int unsigned wt [4];
		o.row = r;
		o.col = c;
		o.we = 1'b1;
		o.pix = '0;
		ew = eff_dim(cfg_width, IMG_W);
		eh = eff_dim(cfg_height, IMG_H);
		md = (cfg_border == BORDER_ALT) ? BORDER_CONST : cfg_border;
		x = warp_mat[0] * longint'(c) + warp_mat[1] * longint'(r) + warp_mat[2];
		y = warp_mat[3] * longint'(c) + warp_mat[4] * longint'(r) + warp_mat[5];
		w = warp_mat[6] * longint'(c) + warp_mat[7] * longint'(r) + warp_mat[8];
		if (w == 0) begin
			if (md == BORDER_TRANSP)
				o.we = 1'b0;
			else
				o.pix = {4{cfg_fill}};
		end else if (cfg_interp == INTERP_NEAREST) begin
			sx = div_nearest(x, w);
			sy = div_nearest(y, w);
			if (md == BORDER_REPL)
				o.pix = src_img[clip(sy, eh - 1) * IMG_W + clip(sx, ew - 1)];
			else if (sy >= 0 && sy < eh && sx >= 0 && sx < ew)
				o.pix = src_img[sy * IMG_W + sx];
			else if (md == BORDER_CONST)
				o.pix = {4{cfg_fill}};
			else
				o.we = 1'b0;
		end else begin
			fx = div_floor_q8(x, w);
			fy = div_floor_q8(y, w);
			x0 = fx >>> 8;
			y0 = fy >>> 8;
			u = int'(fx - x0 * 256);
			v = int'(fy - y0 * 256);
			wt[0] = (256 - u) * (256 - v);
			wt[1] = u * (256 - v);
			wt[2] = (256 - u) * v;
			wt[3] = u * v;
			rr[0] = y0;     cc[0] = x0;
			rr[1] = y0;     cc[1] = x0 + 1;
			rr[2] = y0 + 1; cc[2] = x0;
			rr[3] = y0 + 1; cc[3] = x0 + 1;
			for (int k = 0; k < 4; k++) begin
				if (md == BORDER_REPL) begin
					rr[k] = clip(rr[k], eh - 1);
					cc[k] = clip(cc[k], ew - 1);
				end
				ok[k] = rr[k] >= 0 && rr[k] < eh && cc[k] >= 0 && cc[k] < ew;
				nb[k] = ok[k] ? src_img[rr[k] * IMG_W + cc[k]] : {4{cfg_fill}};
			end
			if (md == BORDER_TRANSP && !(ok[0] && ok[1] && ok[2] && ok[3])) begin
				o.we = 1'b0;
			end else begin
				for (int ch = 0; ch < 4; ch++) begin
					sum = 0;
					for (int k = 0; k < 4; k++)
						sum += nb[k][8*ch +: 8] * wt[k];
					o.pix[8*ch +: 8] = sum[23:16];
				end
			end
		end
		return o;
	endfunction

	task automatic apply_job(job_t j);
		if (j.op == CMD_PIXEL) begin
			if (j.row < IMG_H && j.col < IMG_W)
				src_img[j.row * IMG_W + j.col] = j.pin;
		end else if (j.op == CMD_COEF) begin
			if (j.cidx < 9)
				warp_mat[j.cidx] = {{16{j.cval[47]}}, j.cval};
		end else if (j.op == CMD_COMPUTE) begin
			expected_pixels.push_back(warp_pixel(j.row, j.col));
		end
	endtask

	// driver: one transaction per accepting edge, random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				apply_job(cur_job);
			if (start && busy) begin
				// hold the current transaction
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_jobs.size() > 0 &&
					!(pending_jobs[0].drain && expected_pixels.size() > 0)) begin
				cur_job = pending_jobs.pop_front();
				start <= 1'b1;
				cmd <= cur_job.op;
				pos_row <= cur_job.row;
				pos_col <= cur_job.col;
				coef_index <= cur_job.cidx;
				coef_value <= cur_job.cval;
				pixel_in <= cur_job.pin;
				if (gaps_on && $urandom_range(0, 5) == 0)
					gap_left <= $urandom_range(1, 9);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every strobe must match the oldest prediction
	always @(posedge clk) begin : result_check
		pix_t e;
		if (arst_n && result_valid) begin
			if (expected_pixels.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected result pix=%h we=%b row=%0d col=%0d",
						pixel_out, write_enable, out_row, out_col);
			end else begin
				e = expected_pixels.pop_front();
				if (pixel_out !== e.pix || write_enable !== e.we ||
						out_row !== e.row || out_col !== e.col) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: row=%0d col=%0d exp pix=%h we=%b r=%0d c=%0d got pix=%h we=%b r=%0d c=%0d",
							e.row, e.col, e.pix, e.we, e.row, e.col,
							pixel_out, write_enable, out_row, out_col);
				end
			end
		end
	end

	task automatic push_job(logic [1:0] op, logic [11:0] r, logic [11:0] c,
			logic [3:0] ci, logic [47:0] cv, logic [31:0] pin, bit drain);
		job_t j;
		j.op = op;
		j.row = r;
		j.col = c;
		j.cidx = ci;
		j.cval = cv;
		j.pin = pin;
		j.drain = drain;
		pending_jobs.push_back(j);
	endtask

	task automatic push_coef(int idx, longint signed val);
		push_job(CMD_COEF, 12'($urandom), 12'($urandom), 4'(idx), val[47:0], $urandom, 1'b0);
	endtask

	task automatic push_compute(logic [11:0] r, logic [11:0] c);
		push_job(CMD_COMPUTE, r, c, 4'($urandom), {$urandom, $urandom}, $urandom, 1'b0);
	endtask

	task automatic wait_idle();
		while (pending_jobs.size() > 0 || start || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_BORDER_MODE:   cfg_border = val[1:0];
			REG_INTERP_MODE:   cfg_interp = val[0];
			REG_BORDER_VALUE:  cfg_fill = val[7:0];
			REG_SOURCE_WIDTH:  cfg_width = val[8:0];
			REG_SOURCE_HEIGHT: cfg_height = val[8:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [1:0] bm, logic im, logic [7:0] bv,
			logic [8:0] sw, logic [8:0] sh);
		wait_idle();
		reg_write(REG_BORDER_MODE, {$urandom} & ~32'h3 | bm);
		reg_write(REG_INTERP_MODE, {$urandom} & ~32'h1 | im);
		reg_write(REG_BORDER_VALUE, {24'($urandom), bv});
		reg_write(REG_SOURCE_WIDTH, {23'($urandom), sw});
		reg_write(REG_SOURCE_HEIGHT, {23'($urandom), sh});
	endtask

	// fill every pixel of the active region so no unwritten entry is read
	task automatic load_region();
		longint signed ew, eh;
		ew = eff_dim(cfg_width, IMG_W);
		eh = eff_dim(cfg_height, IMG_H);
		for (int r = 0; r < eh; r++)
			for (int c = 0; c < ew; c++)
				push_job(CMD_PIXEL, 12'(r), 12'(c), 4'($urandom), {$urandom, $urandom},
					$urandom, 1'b0);
	endtask

	function automatic longint signed gen_coef(int kind, int idx);
		longint signed v;
		if (kind == MAT_NOISE)
			return {{16{1'b0}}, 16'($urandom), 32'($urandom)} <<< 16 >>> 16;
		if (kind == MAT_ZERO_W && idx >= 6)
			return 0;
		case (idx)
			0, 4: v = (longint'($urandom_range(0, 196608)) - 98304) <<< 16;
			1, 3: v = (longint'($urandom_range(0, 32768)) - 16384) <<< 16;
			2, 5: v = ((longint'($urandom_range(0, 524288)) - 262144) <<< 16) +
				$urandom_range(0, 65535);
			6, 7: v = (longint'($urandom_range(0, 2048)) - 1024) <<< 16;
			default: begin
				v = longint'($urandom_range(49152, 81920)) <<< 16;
				if ($urandom_range(0, 7) == 0)
					v = -v;
			end
		endcase
		return v;
	endfunction

	task automatic load_matrix(int kind);
		for (int i = 0; i < 9; i++)
			push_coef(i, gen_coef(kind, i));
	endtask

	task automatic load_fixed(longint signed a0, longint signed a2, longint signed a4,
			longint signed a8);
		push_coef(0, a0);
		push_coef(1, 0);
		push_coef(2, a2);
		push_coef(3, 0);
		push_coef(4, a4);
		push_coef(5, a2);
		push_coef(6, 0);
		push_coef(7, 0);
		push_coef(8, a8);
	endtask

	task automatic random_mix(int n);
		longint signed ew, eh, lim;
		int sel, drain_at;
		ew = eff_dim(cfg_width, IMG_W);
		eh = eff_dim(cfg_height, IMG_H);
		lim = 2 * (ew > eh ? ew : eh) + 2;
		if (lim > 4095)
			lim = 4095;
		drain_at = $urandom_range(0, n - 1);
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 80) begin
				if ($urandom_range(0, 9) == 0)
					push_job(CMD_COMPUTE, 12'($urandom), 12'($urandom), 4'($urandom),
						{$urandom, $urandom}, $urandom, i == drain_at);
				else
					push_job(CMD_COMPUTE, 12'($urandom_range(0, lim)),
						12'($urandom_range(0, lim)), 4'($urandom), {$urandom, $urandom},
						$urandom, i == drain_at);
			end else if (sel < 88) begin
				sel = $urandom_range(0, 15);
				push_coef(sel, gen_coef(mat_kind, sel > 8 ? 0 : sel));
			end else if (sel < 95) begin
				if ($urandom_range(0, 1))
					push_job(CMD_PIXEL, 12'($urandom_range(0, eh - 1)),
						12'($urandom_range(0, ew - 1)), 4'($urandom), {$urandom, $urandom},
						$urandom, 1'b0);
				else
					push_job(CMD_PIXEL, 12'($urandom_range(IMG_H, 4095)), 12'($urandom),
						4'($urandom), {$urandom, $urandom}, $urandom, 1'b0);
			end else begin
				push_job(CMD_UNUSED, 12'($urandom), 12'($urandom), 4'($urandom),
					{$urandom, $urandom}, $urandom, 1'b0);
			end
		end
	endtask

	initial begin : stimulus
		logic [1:0] bm;
		logic im;
		logic [7:0] bv;
		logic [8:0] sw, sh;
		int roll;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: nearest, constant border, 4x3 image
		set_config(BORDER_CONST, INTERP_NEAREST, 8'hA5, 9'd4, 9'd3);
		load_region();
		push_job(CMD_PIXEL, 12'd4095, 12'd0, 4'd0, '0, 32'hFFFF_FFFF, 1'b0);
		push_job(CMD_PIXEL, 12'd0, 12'd256, 4'd0, '0, 32'h0, 1'b0);
		push_job(CMD_UNUSED, 12'd4095, 12'd4095, 4'hF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		load_fixed(ONE_Q32, 0, ONE_Q32, ONE_Q32);
		push_compute(12'd0, 12'd0);
		push_compute(12'd2, 12'd3);
		push_compute(12'd3, 12'd3);
		push_compute(12'd4095, 12'd4095);
		// half scale, minus one: quotients land exactly on halves
		load_fixed(ONE_Q32 / 2, -ONE_Q32, ONE_Q32 / 2, ONE_Q32);
		push_compute(12'd1, 12'd1);
		push_compute(12'd5, 12'd7);
		push_coef(8, 0);
		push_compute(12'd1, 12'd1);
		// tiny w saturates the quotient
		push_coef(8, 1);
		push_job(CMD_COEF, 12'd0, 12'd0, 4'hF, 48'h8000_0000_0000, 32'h0, 1'b0);
		push_compute(12'd1, 12'd1);
		push_coef(0, 48'sh7FFF_FFFF_FFFF);
		push_coef(8, 48'sh8000_0000_0000);
		push_compute(12'd4095, 12'd4095);

		for (int p = 0; p < 8; p++) begin
			bm = p < 8 ? 2'(p) : 2'($urandom);
			im = p < 8 ? (p >= 4) : 1'($urandom);
			bv = p == 0 ? 8'h00 : (p == 1 ? 8'hFF : 8'($urandom));
			sw = 9'($urandom_range(1, 4));
			sh = 9'($urandom_range(1, 4));
			if (p == 2) begin
				// width above the store clamps, zero height clamps to one row
				sw = 9'd511;
				sh = 9'd0;
			end else if (p == 5) begin
				sw = 9'd1;
				sh = 9'd2;
			end
			roll = $urandom_range(0, 19);
			mat_kind = roll < 15 ? MAT_WELL : (roll < 18 ? MAT_NOISE : MAT_ZERO_W);
			set_config(bm, im, bv, sw, sh);
			gaps_on = (p < 7) && ($urandom_range(0, 3) != 0);
			load_region();
			load_matrix(mat_kind);
			random_mix(8);
		end

		wait_idle();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
